// ===== rtl/c3e_pkg.sv =====
//------------------------------------------------------------------------------
// c3e_pkg
// Shared types and constants for the 3x3 RGBA convolution block.
//------------------------------------------------------------------------------
package c3e_pkg;

  localparam int unsigned PIX_BITS = 32;
  localparam int unsigned POS_BITS = 10;

  typedef enum logic [2:0] {
    REG_KERNEL_UPPER = 3'd0,
    REG_KERNEL_LOWER = 3'd1,
    REG_NORM_Q8      = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4,
    REG_FILTER_ALPHA = 3'd5
  } reg_index_t;

  // One job for the back end: a 3x3 window already selected, plus position.
  typedef struct packed {
    logic [8:0][PIX_BITS-1:0] win;
    logic [POS_BITS-1:0]      row;
    logic [POS_BITS-1:0]      col;
    logic                     last;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } back_state_t;

endpackage

// ===== rtl/c3e_front.sv =====
//------------------------------------------------------------------------------
// c3e_front
// Line stores, window and raster counters; issues up to four window jobs.
//------------------------------------------------------------------------------
module c3e_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_pix,
  input  logic [10:0]          frame_width,
  input  logic [10:0]          frame_height,
  output logic                 job_valid,
  input  logic                 job_stall,
  output c3e_pkg::job_t        job
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef logic [c3e_pkg::POS_BITS-1:0] pos_t;

  logic [31:0] older_mem [MAX_WIDTH];
  logic [31:0] newer_mem [MAX_WIDTH];
  logic [31:0] older_rd, newer_rd;
  logic [8:0][31:0] win;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  // Phase 0: read line stores. Phase 1: shift window. Phase 2..: emit jobs.
  logic        busy, rd_phase, emit_phase;
  logic [31:0] pix_hold;
  logic [CW-1:0] col_h;
  logic [RW-1:0] row_h;
  logic        lastc_h, lastr_h;
  logic [3:0]  pend;

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [AW-1:0] idx;

  always_comb begin
    if (frame_width == 11'd0) w_eff = CW'(1);
    else if ({21'd0, frame_width} > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(frame_width);
    if (frame_height == 11'd0) h_eff = RW'(1);
    else if ({21'd0, frame_height} > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(frame_height);
  end

  assign idx = ({{(32-CW){1'b0}}, col_h} < MAX_WIDTH) ? col_h[AW-1:0] : AW'(MAX_WIDTH - 1);
  assign in_stall = busy;

  always_ff @(posedge clk) begin
    if (rd_phase) begin
      older_rd <= older_mem[idx];
      newer_rd <= newer_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !rd_phase && !emit_phase) begin
      older_mem[idx] <= newer_rd;
      newer_mem[idx] <= pix_hold;
    end
  end

  // Current job selection from pending mask (lowest bit first).
  logic [1:0] sel;
  logic       prev_r, prev_c;
  logic [3:0] pend_next;
  always_comb begin
    sel = 2'd0;
    if (pend[0]) sel = 2'd0;
    else if (pend[1]) sel = 2'd1;
    else if (pend[2]) sel = 2'd2;
    else sel = 2'd3;
    pend_next = pend;
    pend_next[sel] = 1'b0;
    prev_r = !sel[1];
    prev_c = !sel[0];
  end

  logic [1:0] rsel [3];
  logic [1:0] csel [3];
  always_comb begin
    if (prev_r) begin
      rsel[0] = (row_h >= RW'(2)) ? 2'd0 : 2'd1; rsel[1] = 2'd1; rsel[2] = 2'd2;
    end else begin
      rsel[0] = (row_h >= RW'(1)) ? 2'd1 : 2'd2; rsel[1] = 2'd2; rsel[2] = 2'd2;
    end
    if (prev_c) begin
      csel[0] = (col_h >= CW'(2)) ? 2'd0 : 2'd1; csel[1] = 2'd1; csel[2] = 2'd2;
    end else begin
      csel[0] = (col_h >= CW'(1)) ? 2'd1 : 2'd2; csel[1] = 2'd2; csel[2] = 2'd2;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        job.win[i*3+j] = win[{2'd0, rsel[i]} * 4'd3 + {2'd0, csel[j]}];
      end
    end
    job.row  = prev_r ? pos_t'(row_h - RW'(1)) : pos_t'(row_h);
    job.col  = prev_c ? pos_t'(col_h - CW'(1)) : pos_t'(col_h);
    job.last = (pend_next == 4'd0);
  end

  assign job_valid = emit_phase && (pend != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd_phase <= 1'b0;
      emit_phase <= 1'b0;
      pend <= '0;
      col_count <= '0;
      row_count <= '0;
      win <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        rd_phase <= 1'b1;
        pix_hold <= in_pix;
        col_h <= col_count;
        row_h <= row_count;
        lastc_h <= (col_count + CW'(1)) >= w_eff;
        lastr_h <= (row_count + RW'(1)) >= h_eff;
      end
    end else if (rd_phase) begin
      rd_phase <= 1'b0;
    end else if (!emit_phase) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= older_rd;
      win[5] <= newer_rd;
      win[8] <= pix_hold;
      pend <= {lastr_h && lastc_h, lastr_h && (col_h != '0),
               (row_h != '0) && lastc_h, (row_h != '0) && (col_h != '0)};
      emit_phase <= 1'b1;
      if (lastc_h) begin
        col_count <= '0;
        row_count <= lastr_h ? '0 : row_h + RW'(1);
      end else begin
        col_count <= col_h + CW'(1);
      end
    end else begin
      if (pend == 4'd0) begin
        emit_phase <= 1'b0;
        busy <= 1'b0;
      end else if (!job_stall) begin
        pend <= pend_next;
        if (pend_next == 4'd0) begin
          emit_phase <= 1'b0;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/c3e_queue.sv =====
//------------------------------------------------------------------------------
// c3e_queue
// Two-entry queue between the front end and the arithmetic back end.
//------------------------------------------------------------------------------
module c3e_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  c3e_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_take,
  output c3e_pkg::job_t rd_job
);

  c3e_pkg::job_t slot [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = slot[rp];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/c3e_back.sv =====
//------------------------------------------------------------------------------
// c3e_back
// Weighted sums, scaling by the Q8.8 norm with a serial divider, clamping.
//------------------------------------------------------------------------------
module c3e_back #(
  parameter int COEF_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_take,
  input  c3e_pkg::job_t job,
  input  logic [47:0]   kernel_upper,
  input  logic [23:0]   kernel_lower,
  input  logic [15:0]   norm_q8,
  input  logic          filter_alpha,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_green,
  output logic [7:0]    out_red,
  output logic [7:0]    out_alpha,
  output logic [9:0]    out_row,
  output logic [9:0]    out_col,
  output logic          last_of_run
);

  localparam int PW = COEF_BITS + 9;   // product width
  localparam int SW = PW + 4;          // sum of nine products
  localparam int NW = SW + 8;          // scaled numerator magnitude
  localparam int QC = NW;              // divider steps

  c3e_pkg::back_state_t state, state_next;
  c3e_pkg::job_t        jb;
  logic [1:0]           ch;
  logic [3:0]           tap;
  logic signed [SW-1:0] acc;
  logic                 neg;
  logic [NW-1:0]        num;
  logic [NW-1:0]        quo;
  logic [16:0]          rem;
  logic [$clog2(QC+1)-1:0] step;
  logic [3:0][7:0]      res;

  logic signed [COEF_BITS-1:0] coef;
  logic [7:0]                  pixv;
  logic signed [PW-1:0]        prod;

  // A coefficient field lying beyond the top of its register reads as zero.
  always_comb begin
    if (tap < 4'd6)
      coef = COEF_BITS'({16'd0, kernel_upper} >> (32'(tap) * COEF_BITS));
    else
      coef = COEF_BITS'({40'd0, kernel_lower} >> ((32'(tap) - 32'd6) * COEF_BITS));
    pixv = 8'(jb.win[tap] >> {ch, 3'b000});
    prod = PW'(coef) * $signed({1'b0, pixv});
  end

  logic [16:0] rem_sh;
  logic [7:0]  clamped;
  always_comb begin
    rem_sh = {rem[15:0], num[NW-1]};
    if (neg || quo == '0) clamped = 8'd0;
    else if (quo > NW'(255)) clamped = 8'd255;
    else clamped = quo[7:0];
    if (neg) clamped = 8'd0;
  end

  logic outq_full;
  assign outq_full = out_valid && out_stall;
  assign job_take  = (state == c3e_pkg::ST_IDLE) && job_valid;

  always_comb begin
    state_next = state;
    case (state)
      c3e_pkg::ST_IDLE: if (job_valid) state_next = c3e_pkg::ST_MUL;
      c3e_pkg::ST_MUL:  if (tap == 4'd9) state_next = c3e_pkg::ST_DIV;
      c3e_pkg::ST_DIV: begin
        if (step == '0 && ch == 2'd3) state_next = c3e_pkg::ST_DONE;
        else if (step == '0) state_next = c3e_pkg::ST_MUL;
      end
      c3e_pkg::ST_DONE: if (!outq_full) state_next = c3e_pkg::ST_IDLE;
      default: state_next = c3e_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= c3e_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      c3e_pkg::ST_IDLE: begin
        jb <= job;
        ch <= 2'd0;
        tap <= '0;
        acc <= '0;
      end
      c3e_pkg::ST_MUL: begin
        if (tap != 4'd9) begin
          acc <= acc + SW'(prod);
          tap <= tap + 4'd1;
        end else begin
          neg  <= (acc <= 0);
          num  <= acc[SW-1] ? NW'(-acc) << 8 : NW'(acc) << 8;
          quo  <= '0;
          rem  <= '0;
          step <= ($clog2(QC+1))'(QC);
        end
      end
      c3e_pkg::ST_DIV: begin
        if (step != '0) begin
          num  <= num << 1;
          step <= step - ($clog2(QC+1))'(1);
          if (rem_sh >= {1'b0, norm_q8} && norm_q8 != 16'd0) begin
            rem <= rem_sh - {1'b0, norm_q8};
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[NW-2:0], 1'b0};
          end
        end else begin
          // A zero norm saturates any positive sum.
          res[ch] <= (norm_q8 == 16'd0) ? (neg ? 8'd0 : 8'd255) : clamped;
          ch  <= ch + 2'd1;
          tap <= '0;
          acc <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == c3e_pkg::ST_DONE && !outq_full) begin
        out_valid   <= 1'b1;
        out_blue    <= res[0];
        out_green   <= res[1];
        out_red     <= res[2];
        out_alpha   <= filter_alpha ? res[3] : jb.win[4][31:24];
        out_row     <= jb.row;
        out_col     <= jb.col;
        last_of_run <= jb.last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/conv3x3_rgba_edge_replicate.sv =====
//------------------------------------------------------------------------------
// conv3x3_rgba_edge_replicate
// 3x3 RGBA convolution with border replication over a raster pixel stream.
//------------------------------------------------------------------------------
// Pixels enter on in_valid/in_stall in raster order; results leave on
// out_valid/out_stall, each word one filtered pixel with its row and column.
// Registers are to be written through cfg_valid/cfg_ready only while the
// block is idle; the block itself does not enforce this. Output lags one row
// and one column; the last row and column are flushed as they arrive, so one
// input word yields zero to four output words, the last marked by last_of_run.
// The front end reads the line stores, shifts the window and then issues its
// results one at a time, holding while the queue is full; it takes no new
// pixel until all results of the last one are issued. The back end is a
// sequential datapath: per result, each of the four channels runs a
// multiply-accumulate over the nine taps and then a bit-serial divider; that
// unit sets the throughput. A two-entry queue sits between front and back end.
// Reset clears counters, window and control and restores the box-blur
// settings. A stalled receiver holds the output register and back-pressure
// reaches the input through the queue.
//------------------------------------------------------------------------------
module conv3x3_rgba_edge_replicate #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COEF_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [47:0] kernel_upper;
  logic [23:0] kernel_lower;
  logic [15:0] norm_q8;
  logic [10:0] frame_width, frame_height;
  logic        filter_alpha;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_upper <= 48'h010101010101;
      kernel_lower <= 24'h010101;
      norm_q8      <= 16'd2304;
      frame_width  <= 11'd1024;
      frame_height <= 11'd1024;
      filter_alpha <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        c3e_pkg::REG_KERNEL_UPPER: kernel_upper <= cfg_data;
        c3e_pkg::REG_KERNEL_LOWER: kernel_lower <= cfg_data[23:0];
        c3e_pkg::REG_NORM_Q8:      norm_q8 <= cfg_data[15:0];
        c3e_pkg::REG_FRAME_WIDTH:  frame_width <= cfg_data[10:0];
        c3e_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[10:0];
        c3e_pkg::REG_FILTER_ALPHA: filter_alpha <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic          f_valid, f_stall, q_valid, q_take;
  c3e_pkg::job_t f_job, q_job;

  c3e_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .in_valid, .in_stall,
    .in_pix({in_alpha, in_red, in_green, in_blue}),
    .frame_width, .frame_height,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  c3e_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
    .rd_valid(q_valid), .rd_take(q_take), .rd_job(q_job)
  );

  c3e_back #(.COEF_BITS(COEF_BITS)) u_back (
    .clk, .rst, .job_valid(q_valid), .job_take(q_take), .job(q_job),
    .kernel_upper, .kernel_lower, .norm_q8, .filter_alpha,
    .out_valid, .out_stall, .out_blue, .out_green, .out_red, .out_alpha,
    .out_row, .out_col, .last_of_run
  );

endmodule

// ===== test/conv3x3_rgba_edge_replicate_tb.sv =====
//------------------------------------------------------------------------------
// conv3x3_rgba_edge_replicate_tb
// Self-checking bench for the 3x3 RGBA convolution with border replication.
//------------------------------------------------------------------------------
// A directed table covers the extreme sizes, a size change mid-frame, extreme
// kernels, a zero and a maximal norm and both alpha modes. Random whole frames
// follow, each with fresh settings. Every accepted pixel is run through a
// local model of the line stores and window, and every output word is compared
// with the oldest expected word.
//------------------------------------------------------------------------------
module conv3x3_rgba_edge_replicate_tb;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } filt_word_t;

  typedef enum int {STEP_CFG, STEP_PIX, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t kind;
    c3e_pkg::reg_index_t idx;
    logic [47:0] data;
    logic [31:0] pix;
    bit          known;
    filt_word_t  word;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_blue = '0, in_green = '0, in_red = '0, in_alpha = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_blue, out_green, out_red, out_alpha;
  logic [9:0]  out_row, out_col;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // Local copy of the block's settings and state.
  logic [47:0] k_upper;
  logic [23:0] k_lower;
  logic [15:0] norm;
  logic [10:0] fr_width, fr_height;
  logic        alpha_filt;
  logic [31:0] older_pix [1024];
  logic [31:0] newer_pix [1024];
  logic [31:0] win [9];
  int unsigned col_cnt, row_cnt;

  filt_word_t  filt_expect_q[$];
  filt_word_t  step_words[$];
  table_row_t  steps[$];

  int          errors = 0;
  int          pixels_sent = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;

  conv3x3_rgba_edge_replicate dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red), .in_alpha(in_alpha),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .out_alpha(out_alpha), .out_row(out_row), .out_col(out_col),
    .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #40000000;
    $display("conv3x3_rgba_edge_replicate_tb NOT OK");
    $finish;
  end

  function automatic longint coef(int n);
    logic [7:0] f;
    f = (n < 6) ? k_upper[n*8 +: 8] : k_lower[(n-6)*8 +: 8];
    return longint'($signed(f));
  endfunction

  function automatic logic [7:0] scale_clamp(longint sum);
    longint q;
    if (norm == 0) return (sum > 0) ? 8'd255 : 8'd0;
    q = (sum * 256) / longint'(norm);
    if (q > 255) return 8'd255;
    if (q < 0) return 8'd0;
    return q[7:0];
  endfunction

  // Rows and columns of the window are picked as (r0, r1, 2) and (c0, c1, 2).
  function automatic filt_word_t window_sum(int r0, int r1, int c0, int c1,
                                            int unsigned row, int unsigned col);
    filt_word_t w;
    int rs[3];
    int cs[3];
    logic [7:0] ch[4];
    longint sum;
    rs[0] = r0; rs[1] = r1; rs[2] = 2;
    cs[0] = c0; cs[1] = c1; cs[2] = 2;
    for (int c = 0; c < 4; c++) begin
      sum = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          sum += coef(i*3 + j) * longint'(win[rs[i]*3 + cs[j]][8*c +: 8]);
      ch[c] = scale_clamp(sum);
    end
    if (!alpha_filt) ch[3] = win[rs[1]*3 + cs[1]][31:24];
    w.blue = ch[0]; w.green = ch[1]; w.red = ch[2]; w.alpha = ch[3];
    w.row = row[9:0];
    w.col = col[9:0];
    w.last = 1'b0;
    return w;
  endfunction

  task automatic filter_pixel(input logic [31:0] pix);
    int unsigned w, h, col, row, idx;
    bit lastc, lastr;
    w = (fr_width == 0) ? 1 : (fr_width > 1024) ? 1024 : fr_width;
    h = (fr_height == 0) ? 1 : (fr_height > 1024) ? 1024 : fr_height;
    col = col_cnt;
    row = row_cnt;
    idx = (col < 1024) ? col : 1023;
    lastc = (col + 1 >= w);
    lastr = (row + 1 >= h);
    step_words.delete();
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3 + 1];
      win[r*3 + 1] = win[r*3 + 2];
    end
    win[2] = older_pix[idx];
    win[5] = newer_pix[idx];
    win[8] = pix;
    older_pix[idx] = newer_pix[idx];
    newer_pix[idx] = pix;
    if (row >= 1) begin
      if (col >= 1)
        step_words.push_back(window_sum(row >= 2 ? 0 : 1, 1, col >= 2 ? 0 : 1, 1,
                                        row - 1, col - 1));
      if (lastc)
        step_words.push_back(window_sum(row >= 2 ? 0 : 1, 1, col >= 1 ? 1 : 2, 2,
                                        row - 1, col));
    end
    if (lastr) begin
      if (col >= 1)
        step_words.push_back(window_sum(row >= 1 ? 1 : 2, 2, col >= 2 ? 0 : 1, 1,
                                        row, col - 1));
      if (lastc)
        step_words.push_back(window_sum(row >= 1 ? 1 : 2, 2, col >= 1 ? 1 : 2, 2,
                                        row, col));
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
    if (lastc) begin
      col_cnt = 0;
      row_cnt = lastr ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // Called at a falling edge; waits until no word is outstanding, then writes
  // and returns at a falling edge once cfg_valid has been dropped.
  task automatic write_reg(input c3e_pkg::reg_index_t idx, input logic [47:0] data);
    in_valid <= 1'b0;
    while (filt_expect_q.size() > 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      c3e_pkg::REG_KERNEL_UPPER: k_upper = data;
      c3e_pkg::REG_KERNEL_LOWER: k_lower = data[23:0];
      c3e_pkg::REG_NORM_Q8:      norm = data[15:0];
      c3e_pkg::REG_FRAME_WIDTH:  fr_width = data[10:0];
      c3e_pkg::REG_FRAME_HEIGHT: fr_height = data[10:0];
      c3e_pkg::REG_FILTER_ALPHA: alpha_filt = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(input logic [31:0] pix, input bit known,
                            input filt_word_t word);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_alpha, in_red, in_green, in_blue} <= pix;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    filter_pixel(pix);
    if (known) filt_expect_q.push_back(word);
    else foreach (step_words[i]) filt_expect_q.push_back(step_words[i]);
    pixels_sent++;
    @(negedge clk);
  endtask

  // The last pixel sent may cause no word, so allow the block time to settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (filt_expect_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic table_row_t cfg_row(c3e_pkg::reg_index_t idx, logic [47:0] data);
    table_row_t t;
    t.kind = STEP_CFG; t.idx = idx; t.data = data; t.pix = '0; t.known = 0; t.word = '0;
    return t;
  endfunction

  function automatic table_row_t pix_row(logic [31:0] pix);
    table_row_t t;
    t.kind = STEP_PIX; t.idx = c3e_pkg::REG_KERNEL_UPPER; t.data = '0; t.pix = pix;
    t.known = 0; t.word = '0;
    return t;
  endfunction

  always @(negedge clk) begin
    int hold_left;
    bit hold_taken;
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    filt_word_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_blue, out_green, out_red, out_alpha, out_row, out_col, last_of_run};
      if (filt_expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %p", got);
      end else begin
        want = filt_expect_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    table_row_t t;
    int w, h;
    k_upper = 48'h010101010101;
    k_lower = 24'h010101;
    norm = 16'd2304;
    fr_width = 11'd1024;
    fr_height = 11'd1024;
    alpha_filt = 1'b0;
    foreach (win[i]) win[i] = '0;
    foreach (older_pix[i]) begin
      older_pix[i] = '0;
      newer_pix[i] = '0;
    end
    col_cnt = 0;
    row_cnt = 0;

    // Zero sizes mean a 1x1 frame: the box blur then returns the pixel itself.
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_WIDTH, 48'd0));
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_HEIGHT, 48'd0));
    t = pix_row(32'h01_80_00_ff);
    t.known = 1; t.word = '{8'hff, 8'h00, 8'h80, 8'h01, 10'd0, 10'd0, 1'b1};
    steps.push_back(t);
    t = pix_row(32'hfe_01_ff_00);
    t.known = 1; t.word = '{8'h00, 8'hff, 8'h01, 8'hfe, 10'd0, 10'd0, 1'b1};
    steps.push_back(t);
    // Oversized frame, then shrunk under a running counter so it wraps.
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_WIDTH, 48'd2047));
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_HEIGHT, 48'd2047));
    steps.push_back(pix_row(32'h55_aa_55_aa));
    steps.push_back(pix_row(32'hff_ff_ff_ff));
    steps.push_back(pix_row(32'h00_00_00_00));
    steps.push_back('{STEP_DRAIN, c3e_pkg::REG_KERNEL_UPPER, '0, '0, 0, '0});
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_WIDTH, 48'd3));
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_HEIGHT, 48'd1));
    steps.push_back(pix_row(32'haa_55_aa_55));
    steps.push_back('{STEP_DRAIN, c3e_pkg::REG_KERNEL_UPPER, '0, '0, 0, '0});
    // Extreme coefficients with a zero norm and filtered alpha.
    steps.push_back(cfg_row(c3e_pkg::REG_KERNEL_UPPER, 48'h7f807f807f80));
    steps.push_back(cfg_row(c3e_pkg::REG_KERNEL_LOWER, 48'h807f80));
    steps.push_back(cfg_row(c3e_pkg::REG_NORM_Q8, 48'd0));
    steps.push_back(cfg_row(c3e_pkg::REG_FILTER_ALPHA, 48'd1));
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_HEIGHT, 48'd2));
    steps.push_back(pix_row(32'hff_00_ff_00));
    steps.push_back(pix_row(32'h00_ff_00_ff));
    steps.push_back(pix_row(32'hff_ff_ff_ff));
    steps.push_back(pix_row(32'h00_00_00_00));
    steps.push_back(pix_row(32'h80_7f_01_fe));
    steps.push_back(pix_row(32'h01_fe_80_7f));
    steps.push_back('{STEP_DRAIN, c3e_pkg::REG_KERNEL_UPPER, '0, '0, 0, '0});
    // Mixed-sign kernel with the largest norm.
    steps.push_back(cfg_row(c3e_pkg::REG_KERNEL_UPPER, 48'h01ff0201ff01));
    steps.push_back(cfg_row(c3e_pkg::REG_KERNEL_LOWER, 48'h010201));
    steps.push_back(cfg_row(c3e_pkg::REG_NORM_Q8, 48'hffff));
    steps.push_back(cfg_row(c3e_pkg::REG_FILTER_ALPHA, 48'd0));
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_WIDTH, 48'd2));
    steps.push_back(cfg_row(c3e_pkg::REG_FRAME_HEIGHT, 48'd3));
    for (int i = 0; i < 6; i++) steps.push_back(pix_row({4{8'(i * 51)}}));

    send_gap_pct = 14;
    recv_stall_pct = 59;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (steps[i]) begin
      case (steps[i].kind)
        STEP_CFG:   write_reg(steps[i].idx, steps[i].data);
        STEP_PIX:   send_pixel(steps[i].pix, steps[i].known, steps[i].word);
        STEP_DRAIN: drain();
        default: ;
      endcase
    end
    drain();

    // Random whole frames; the first is a 6x5 one, the largest the random sizes
    // allow, sent into a long output hold-off.
    while (pixels_sent < 255) begin
      if (pixels_sent < 110) begin
        send_gap_pct = 14; recv_stall_pct = 59;
      end else if (pixels_sent < 200) begin
        send_gap_pct = 59; recv_stall_pct = 14;
      end else begin
        send_gap_pct = 0; recv_stall_pct = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(c3e_pkg::REG_KERNEL_UPPER, 48'h010101010101);
        write_reg(c3e_pkg::REG_KERNEL_LOWER, 48'h010101);
      end else begin
        write_reg(c3e_pkg::REG_KERNEL_UPPER, 48'({$urandom, $urandom}));
        write_reg(c3e_pkg::REG_KERNEL_LOWER, 48'($urandom));
      end
      write_reg(c3e_pkg::REG_NORM_Q8,
                ($urandom_range(0, 4) == 0) ? 48'($urandom_range(0, 65535))
                                            : 48'($urandom_range(256, 4096)));
      w = $urandom_range(0, 6);
      h = $urandom_range(0, 5);
      if (!hold_req) begin
        w = 6;
        h = 5;
      end
      write_reg(c3e_pkg::REG_FRAME_WIDTH, 48'(w));
      write_reg(c3e_pkg::REG_FRAME_HEIGHT, 48'(h));
      write_reg(c3e_pkg::REG_FILTER_ALPHA, 48'($urandom_range(0, 1)));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      hold_req = 1'b1;
      for (int i = 0; i < w * h; i++) send_pixel($urandom, 1'b0, '0);
      drain();
    end

    if (errors == 0 && filt_expect_q.size() == 0)
      $display("conv3x3_rgba_edge_replicate_tb OK");
    else
      $display("conv3x3_rgba_edge_replicate_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/c3e_pkg.sv
rtl/c3e_front.sv
rtl/c3e_queue.sv
rtl/c3e_back.sv
rtl/conv3x3_rgba_edge_replicate.sv
test/conv3x3_rgba_edge_replicate_tb.sv
